### sv/srg_pkg.sv
package srg_pkg;

    // table geometry and lags
    localparam int TABLE_LEN    = 55;
    localparam int SHORT_LAG    = 24;
    localparam int LONG_OFFSET  = 31;
    localparam int SCATTER_STEP = 21;
    localparam int REF_PASSES   = 4;
    localparam int WORD_W       = 16;
    localparam int RANGE_W      = 17;
    localparam int ADDR_W       = $clog2(TABLE_LEN);
    localparam int STEP_W       = 4;
    localparam int PASS_W       = $clog2(REF_PASSES + 1);

    localparam logic [RANGE_W-1:0] RANGE_MAX = RANGE_W'(65536);
    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(TABLE_LEN - 1);

    // operation selector on the input tuser
    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    // program steps
    localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DRAW_OUT  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_DISPATCH  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_SEED_INIT = 4'd3;
    localparam logic [STEP_W-1:0] STEP_SEED_LOOP = 4'd4;
    localparam logic [STEP_W-1:0] STEP_SEED_END  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_REF_RD    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_REF_WR    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_REF_DONE  = 4'd8;

    // datapath actions
    localparam logic [3:0] ACT_IDLE      = 4'd0;
    localparam logic [3:0] ACT_DRAW_OUT  = 4'd1;
    localparam logic [3:0] ACT_WRAP_SET  = 4'd2;
    localparam logic [3:0] ACT_SEED_INIT = 4'd3;
    localparam logic [3:0] ACT_SEED_STEP = 4'd4;
    localparam logic [3:0] ACT_SEED_END  = 4'd5;
    localparam logic [3:0] ACT_REF_RD    = 4'd6;
    localparam logic [3:0] ACT_REF_WR    = 4'd7;
    localparam logic [3:0] ACT_REF_DONE  = 4'd8;

    // hold conditions: the step repeats until the condition is met
    localparam logic [1:0] HOLD_NONE     = 2'd0;
    localparam logic [1:0] HOLD_IN_VALID = 2'd1;
    localparam logic [1:0] HOLD_OUT_FREE = 2'd2;

    // branch conditions
    localparam logic [2:0] COND_ALWAYS    = 3'd0;
    localparam logic [2:0] COND_FAST_DRAW = 3'd1;
    localparam logic [2:0] COND_OP_SEED   = 3'd2;
    localparam logic [2:0] COND_P_LAST    = 3'd3;
    localparam logic [2:0] COND_REF_LAST  = 3'd4;
    localparam logic [2:0] COND_IS_DRAW   = 3'd5;

    typedef struct packed {
        logic [3:0]        act;
        logic [1:0]        hold;
        logic [2:0]        cond;
        logic [STEP_W-1:0] tgt_true;
        logic [STEP_W-1:0] tgt_false;
    } t_ctrl_word;

    // control store
    function automatic t_ctrl_word ctrl_rom(input logic [STEP_W-1:0] step);
        t_ctrl_word w;
        unique case (step)
            STEP_IDLE:      w = '{ACT_IDLE, HOLD_IN_VALID, COND_FAST_DRAW,
                                  STEP_DRAW_OUT, STEP_DISPATCH};
            STEP_DRAW_OUT:  w = '{ACT_DRAW_OUT, HOLD_OUT_FREE, COND_ALWAYS,
                                  STEP_IDLE, STEP_IDLE};
            STEP_DISPATCH:  w = '{ACT_WRAP_SET, HOLD_NONE, COND_OP_SEED,
                                  STEP_SEED_INIT, STEP_REF_RD};
            STEP_SEED_INIT: w = '{ACT_SEED_INIT, HOLD_NONE, COND_ALWAYS,
                                  STEP_SEED_LOOP, STEP_SEED_LOOP};
            STEP_SEED_LOOP: w = '{ACT_SEED_STEP, HOLD_NONE, COND_P_LAST,
                                  STEP_SEED_END, STEP_SEED_LOOP};
            STEP_SEED_END:  w = '{ACT_SEED_END, HOLD_NONE, COND_ALWAYS,
                                  STEP_REF_RD, STEP_REF_RD};
            STEP_REF_RD:    w = '{ACT_REF_RD, HOLD_NONE, COND_ALWAYS,
                                  STEP_REF_WR, STEP_REF_WR};
            STEP_REF_WR:    w = '{ACT_REF_WR, HOLD_NONE, COND_REF_LAST,
                                  STEP_REF_DONE, STEP_REF_RD};
            STEP_REF_DONE:  w = '{ACT_REF_DONE, HOLD_NONE, COND_IS_DRAW,
                                  STEP_DRAW_OUT, STEP_IDLE};
            default:        w = '{ACT_IDLE, HOLD_NONE, COND_ALWAYS,
                                  STEP_IDLE, STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

### sv/subtractive_random_generator.sv
// Subtractive lagged random generator, lags 55 and 24, 16-bit words.
// Input channel (i_s_*): tuser carries the operation, 0 draws a number and
// 1 reseeds the table; tdata carries the seed and the range limit n.
// Output channel (o_m_*): one item per draw with the raw table word and
// the word scaled into 0..n-1 (n capped at 65536); a reseed gives no item.
// Control is a small microprogram stepping a memory-based datapath.
// A plain draw: the item is taken in the idle step while the table read
// issues, and the next step loads the output register.
// A draw that wraps the read position runs one table refresh first,
// entry by entry over one write port.
// A reseed scatters the seed over the table and runs four refreshes,
// during which no item is taken.
// Reset (synchronous, active low) clears the table through per-entry valid
// bits at once and sets the read position to 0; no clearing pass is needed.
// A stalled receiver holds the output register; the block still takes the
// next item, and a draw then waits in its output step until the register
// is free.
module subtractive_random_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // seed_value[15:0], range_limit[32:16], zero pad
    input  logic        i_s_tuser,   // operation[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // raw_value[15:0], scaled_value[31:16]
);

    localparam int TABLE_LEN = srg_pkg::TABLE_LEN;
    localparam int ADDR_W = $clog2(TABLE_LEN);
    localparam int WORD_W = srg_pkg::WORD_W;
    localparam int RANGE_W = srg_pkg::RANGE_W;
    localparam int STEP_W = srg_pkg::STEP_W;
    localparam int PASS_W = srg_pkg::PASS_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_LEN - 1);
    localparam logic [ADDR_W-1:0] SCATTER = ADDR_W'(srg_pkg::SCATTER_STEP);
    localparam logic [ADDR_W-1:0] LONG_OFF = ADDR_W'(srg_pkg::LONG_OFFSET);
    localparam logic [ADDR_W-1:0] SHORT_LAG = ADDR_W'(srg_pkg::SHORT_LAG);
    localparam logic [ADDR_W-1:0] TABLE_SZ = ADDR_W'(TABLE_LEN);
    localparam logic [ADDR_W-1:0] FIRST_SLOT =
        ADDR_W'((srg_pkg::SCATTER_STEP + TABLE_LEN - 1) % TABLE_LEN);

    // sequencer state
    logic [STEP_W-1:0] r_pc, n_pc;
    srg_pkg::t_ctrl_word w_ctrl;

    // datapath registers
    logic [ADDR_W-1:0]  r_rp, r_p, r_slot;
    logic [PASS_W-1:0]  r_passes;
    logic               r_is_draw;
    logic               r_op;
    logic [WORD_W-1:0]  r_seed;
    logic [RANGE_W-1:0] r_n;
    logic [WORD_W-1:0]  r_prev, r_cur;

    // table memory with per-entry valid bits
    logic [WORD_W-1:0]    mem [TABLE_LEN];
    logic [TABLE_LEN-1:0] r_valid;
    logic [WORD_W-1:0]    r_rd_a, r_rd_b;
    logic                 r_va, r_vb;

    // output register
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_raw, r_scaled;

    logic               w_accept, w_fast, w_out_free, w_hold_ok, w_cond;
    logic               w_rd_en, w_wr_en;
    logic [ADDR_W-1:0]  w_rd_addr_a, w_rd_addr_b, w_wr_addr;
    logic [WORD_W-1:0]  w_wr_data, w_a, w_b;
    logic [ADDR_W:0]    w_slot_sum;
    logic [RANGE_W-1:0] w_n_sat;
    logic [WORD_W+RANGE_W-1:0] w_prod;

    assign w_ctrl     = srg_pkg::ctrl_rom(r_pc);
    assign o_s_tready = (w_ctrl.act == srg_pkg::ACT_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_fast     = (i_s_tuser == srg_pkg::OP_DRAW) && (r_rp != LAST_ADDR);
    assign w_out_free = !r_out_valid || i_m_tready;

    // masked read data: never-written entries read as zero
    assign w_a = r_va ? r_rd_a : '0;
    assign w_b = r_vb ? r_rd_b : '0;

    // hold and branch evaluation
    always_comb begin
        unique case (w_ctrl.hold)
            srg_pkg::HOLD_NONE:     w_hold_ok = 1'b1;
            srg_pkg::HOLD_IN_VALID: w_hold_ok = i_s_tvalid;
            srg_pkg::HOLD_OUT_FREE: w_hold_ok = w_out_free;
            default:                w_hold_ok = 1'b1;
        endcase
        unique case (w_ctrl.cond)
            srg_pkg::COND_ALWAYS:    w_cond = 1'b1;
            srg_pkg::COND_FAST_DRAW: w_cond = w_fast;
            srg_pkg::COND_OP_SEED:   w_cond = (r_op == srg_pkg::OP_RESEED);
            srg_pkg::COND_P_LAST:    w_cond = (r_p == LAST_ADDR);
            srg_pkg::COND_REF_LAST:  w_cond = (r_p == LAST_ADDR) && (r_passes == PASS_W'(1));
            srg_pkg::COND_IS_DRAW:   w_cond = r_is_draw;
            default:                 w_cond = 1'b1;
        endcase
        if (!w_hold_ok) begin
            n_pc = r_pc;
        end else if (w_cond) begin
            n_pc = w_ctrl.tgt_true;
        end else begin
            n_pc = w_ctrl.tgt_false;
        end
    end

    // memory port control
    assign w_slot_sum = {1'b0, r_slot} + {1'b0, SCATTER};

    always_comb begin
        w_rd_en     = 1'b0;
        w_rd_addr_a = r_p;
        w_rd_addr_b = (r_p < SHORT_LAG) ? (r_p + LONG_OFF) : (r_p - SHORT_LAG);
        w_wr_en     = 1'b0;
        w_wr_addr   = r_p;
        w_wr_data   = w_a - w_b;
        unique case (w_ctrl.act)
            srg_pkg::ACT_IDLE: begin
                w_rd_en     = w_accept && w_fast;
                w_rd_addr_a = r_rp + ADDR_W'(1);
            end
            srg_pkg::ACT_SEED_INIT: begin
                w_wr_en   = 1'b1;
                w_wr_addr = LAST_ADDR;
                w_wr_data = r_seed;
            end
            srg_pkg::ACT_SEED_STEP: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_slot;
                w_wr_data = r_cur;
            end
            srg_pkg::ACT_REF_RD: begin
                w_rd_en = 1'b1;
            end
            srg_pkg::ACT_REF_WR: begin
                w_wr_en = 1'b1;
            end
            srg_pkg::ACT_REF_DONE: begin
                w_rd_en     = 1'b1;
                w_rd_addr_a = '0;
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    // table memory, registered reads
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_a <= mem[w_rd_addr_a];
            r_rd_b <= mem[w_rd_addr_b];
        end
    end

    // valid bits and their registered copies
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
        end else begin
            if (w_wr_en) begin
                r_valid[w_wr_addr] <= 1'b1;
            end
            if (w_rd_en) begin
                r_va <= r_valid[w_rd_addr_a];
                r_vb <= r_valid[w_rd_addr_b];
            end
        end
    end

    // scaled draw
    assign w_n_sat = r_n[RANGE_W-1] ? srg_pkg::RANGE_MAX : r_n;
    assign w_prod  = w_a * w_n_sat;

    // sequencer and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= srg_pkg::STEP_IDLE;
            r_rp        <= '0;
            r_p         <= '0;
            r_slot      <= '0;
            r_passes    <= '0;
            r_is_draw   <= 1'b0;
            r_op        <= srg_pkg::OP_DRAW;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            // output valid: load in the output step, else release on ready
            if ((w_ctrl.act == srg_pkg::ACT_DRAW_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (w_ctrl.act)
                srg_pkg::ACT_IDLE: begin
                    if (w_accept) begin
                        r_op <= i_s_tuser;
                        if (w_fast) begin
                            r_rp <= r_rp + ADDR_W'(1);
                        end
                    end
                end
                srg_pkg::ACT_WRAP_SET: begin
                    r_p       <= '0;
                    r_passes  <= PASS_W'(1);
                    r_is_draw <= 1'b1;
                end
                srg_pkg::ACT_SEED_INIT: begin
                    r_p    <= ADDR_W'(1);
                    r_slot <= FIRST_SLOT;
                end
                srg_pkg::ACT_SEED_STEP: begin
                    r_p    <= r_p + ADDR_W'(1);
                    r_slot <= (w_slot_sum >= {1'b0, TABLE_SZ})
                            ? ADDR_W'(w_slot_sum - {1'b0, TABLE_SZ})
                            : w_slot_sum[ADDR_W-1:0];
                end
                srg_pkg::ACT_SEED_END: begin
                    r_p       <= '0;
                    r_passes  <= PASS_W'(srg_pkg::REF_PASSES);
                    r_is_draw <= 1'b0;
                end
                srg_pkg::ACT_REF_WR: begin
                    if (r_p == LAST_ADDR) begin
                        r_p      <= '0;
                        r_passes <= r_passes - PASS_W'(1);
                    end else begin
                        r_p <= r_p + ADDR_W'(1);
                    end
                end
                srg_pkg::ACT_REF_DONE: begin
                    r_rp <= '0;
                end
                default: begin
                    r_op <= r_op;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_seed <= i_s_tdata[WORD_W-1:0];
            r_n    <= i_s_tdata[WORD_W+RANGE_W-1:WORD_W];
        end
        unique case (w_ctrl.act)
            srg_pkg::ACT_SEED_INIT: begin
                r_prev <= r_seed;
                r_cur  <= WORD_W'(1);
            end
            srg_pkg::ACT_SEED_STEP: begin
                r_prev <= r_cur;
                r_cur  <= r_prev - r_cur;
            end
            srg_pkg::ACT_DRAW_OUT: begin
                if (w_out_free) begin
                    r_raw    <= w_a;
                    r_scaled <= w_prod[2*WORD_W-1:WORD_W];
                end
            end
            default: begin
                r_cur <= r_cur;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_scaled, r_raw};

`ifndef SYNTHESIS
    // an accepted item takes the sequencer out of its idle step
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_tready)
        else $error("input taken twice in a row");

    // a refresh always runs with at least one pass left and in-range pointers
    a_refresh_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == srg_pkg::STEP_REF_WR) |->
            (r_passes != '0) && (r_p <= LAST_ADDR) && (r_rp <= LAST_ADDR))
        else $error("refresh pass count or pointer out of range");

    // the output step loads a result as soon as the register is free
    a_draw_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pc == srg_pkg::STEP_DRAW_OUT) && w_out_free) |=>
            o_m_tvalid && (r_pc == srg_pkg::STEP_IDLE))
        else $error("draw result not loaded");
`endif

endmodule

### bench/srg_checker.sv
module srg_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,   // seed_value[15:0], range_limit[32:16], zero pad
    input  logic        i_s_tuser,   // operation[0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // raw_value[15:0], scaled_value[31:16]
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [15:0] raw;
        logic [15:0] scaled;
    } t_draw_result;

    // predicted generator state
    logic [15:0]  lag_words [srg_pkg::TABLE_LEN];
    int           draw_pos;
    t_draw_result pending_draws [$];
    int           errors;

    // one pass over the table: low part looks ahead, high part looks back
    function automatic void refresh_lag_words();
        for (int p = 0; p < srg_pkg::SHORT_LAG; p++)
            lag_words[p] = lag_words[p] - lag_words[p + srg_pkg::LONG_OFFSET];
        for (int p = srg_pkg::SHORT_LAG; p < srg_pkg::TABLE_LEN; p++)
            lag_words[p] = lag_words[p] - lag_words[p - srg_pkg::SHORT_LAG];
    endfunction

    // scatter the seed over the table, then stir it
    function automatic void reseed_lag_words(input logic [15:0] seed);
        logic [15:0] cur;
        logic [15:0] prev;
        logic [15:0] nxt;
        int          slot;
        cur  = 16'd1;
        prev = seed;
        lag_words[srg_pkg::TABLE_LEN - 1] = seed;
        for (int p = 1; p < srg_pkg::TABLE_LEN; p++) begin
            slot = ((srg_pkg::SCATTER_STEP * p) % srg_pkg::TABLE_LEN
                    + srg_pkg::TABLE_LEN - 1) % srg_pkg::TABLE_LEN;
            lag_words[slot] = cur;
            nxt  = prev - cur;
            prev = cur;
            cur  = nxt;
        end
        for (int r = 0; r < srg_pkg::REF_PASSES; r++)
            refresh_lag_words();
        draw_pos = 0;
    endfunction

    // advance the position, refresh on wrap, scale the drawn word
    function automatic t_draw_result draw_word(input logic [16:0] range_limit);
        t_draw_result res;
        logic [16:0]  n;
        logic [32:0]  product;
        draw_pos = draw_pos + 1;
        if (draw_pos >= srg_pkg::TABLE_LEN) begin
            refresh_lag_words();
            draw_pos = 0;
        end
        n          = (range_limit > srg_pkg::RANGE_MAX) ? srg_pkg::RANGE_MAX : range_limit;
        res.raw    = lag_words[draw_pos];
        product    = res.raw * n;
        res.scaled = product[31:16];
        return res;
    endfunction

    initial begin
        errors       = 0;
        draw_pos     = 0;
        o_fail_count = 0;
        o_pending    = 0;
        foreach (lag_words[i])
            lag_words[i] = '0;
    end

    // compare finished draws, then predict the newly accepted item
    always @(posedge i_clk) begin
        t_draw_result want;
        if (!i_rst_n) begin
            foreach (lag_words[i])
                lag_words[i] = '0;
            draw_pos = 0;
            pending_draws.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (pending_draws.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual %h",
                             $time, i_m_tdata);
                    errors++;
                end else begin
                    want = pending_draws.pop_front();
                    if (i_m_tdata[15:0] !== want.raw) begin
                        $display("%0t: raw_value mismatch, expected %h, actual %h",
                                 $time, want.raw, i_m_tdata[15:0]);
                        errors++;
                    end
                    if (i_m_tdata[31:16] !== want.scaled) begin
                        $display("%0t: scaled_value mismatch, expected %h, actual %h",
                                 $time, want.scaled, i_m_tdata[31:16]);
                        errors++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == srg_pkg::OP_RESEED)
                    reseed_lag_words(i_s_tdata[15:0]);
                else
                    pending_draws.push_back(draw_word(i_s_tdata[32:16]));
            end
        end
        o_fail_count <= errors;
        o_pending    <= pending_draws.size();
    end

endmodule

### bench/tb_subtractive_random_generator.sv
module tb_subtractive_random_generator;

    localparam int RANDOM_ITEMS   = 1700;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 150;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata  = '0;   // seed_value[15:0], range_limit[32:16], zero pad
    logic        i_s_tuser  = 1'b0; // operation[0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;         // raw_value[15:0], scaled_value[31:16]

    int fail_count;
    int draws_pending;
    int quiet_cycles = 0;
    bit long_hold_req = 1'b0;
    bit steady = 1'b0;

    always #5 i_clk = ~i_clk;

    subtractive_random_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    srg_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (draws_pending)
    );

    // idle length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // range limit: full field, tiny, around the saturation point, in range
    function automatic logic [16:0] pick_range();
        case ($urandom_range(0, 3))
            0:       return 17'($urandom_range(0, 131071));
            1:       return 17'($urandom_range(0, 16));
            2:       return 17'($urandom_range(65530, 65542));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // offer one item and hold it until the block takes it
    task automatic offer_item(input logic op, input logic [15:0] seed,
                              input logic [16:0] range_limit);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {7'b0, range_limit, seed};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
    endtask

    task automatic idle_sender(input int gap);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_draws();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (draws_pending != 0)
            @(posedge i_clk);
    endtask

    // receiver: random ready runs, a steady stretch and one long hold
    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (steady) begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
                gap = pick_gap();
                if (gap > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        int burst_left;
        logic op;
        burst_left = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // draws from the cleared table give zeros
        offer_item(srg_pkg::OP_DRAW, 16'hffff, 17'd65535);
        offer_item(srg_pkg::OP_DRAW, 16'h0000, 17'h1ffff);
        idle_sender(pick_gap());
        offer_item(srg_pkg::OP_DRAW, 16'h5a5a, 17'd0);

        // zero seed, then range extremes including saturation
        offer_item(srg_pkg::OP_RESEED, 16'h0000, 17'h1ffff);
        offer_item(srg_pkg::OP_DRAW, 16'h0000, 17'd0);
        offer_item(srg_pkg::OP_DRAW, 16'hffff, 17'd1);
        offer_item(srg_pkg::OP_DRAW, 16'h0000, 17'd65535);
        idle_sender(pick_gap());
        offer_item(srg_pkg::OP_DRAW, 16'h0000, 17'd65536);
        offer_item(srg_pkg::OP_DRAW, 16'h0000, 17'd65537);
        offer_item(srg_pkg::OP_DRAW, 16'h0000, 17'h1ffff);

        // all-ones seed and a back-to-back reseed
        offer_item(srg_pkg::OP_RESEED, 16'hffff, 17'd0);
        offer_item(srg_pkg::OP_DRAW, 16'h1234, 17'd2);
        offer_item(srg_pkg::OP_DRAW, 16'h0000, 17'd65536);
        offer_item(srg_pkg::OP_RESEED, 16'h8001, 17'h10000);
        offer_item(srg_pkg::OP_RESEED, 16'h1234, 17'h0ffff);
        offer_item(srg_pkg::OP_DRAW, 16'hffff, 17'd3);
        offer_item(srg_pkg::OP_DRAW, 16'h0000, 17'd65535);
        idle_sender(pick_gap());
        offer_item(srg_pkg::OP_DRAW, 16'h0000, 17'd100);

        // random mix: long draw runs between rare reseeds
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == 400) begin
                long_hold_req = 1'b1;
                burst_left    = 30;
            end
            if (k == 1000) begin
                steady     = 1'b1;
                burst_left = 150;
            end
            if (k == 1150)
                steady = 1'b0;
            if (k == 1300)
                drain_draws();
            op = ($urandom_range(0, 59) == 0) ? srg_pkg::OP_RESEED : srg_pkg::OP_DRAW;
            offer_item(op, 16'($urandom_range(0, 65535)), pick_range());
            if (burst_left > 0)
                burst_left--;
            else
                idle_sender(pick_gap());
        end

        // wait for the last draws, then let the block settle
        drain_draws();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && draws_pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
